// File: hdl/mmfs_pkg.sv
// Package for the min-max feature scaler: field widths, beat payload types
// and the command and status structs between controller and datapath.
// No dependencies.
package mmfs_pkg;

  localparam int unsigned SAMPLE_BITS       = 32;
  localparam int unsigned FRACTION_BITS     = 16;
  localparam int unsigned STORE_DEPTH_DEF   = 64;
  localparam int unsigned SCALED_BITS       = FRACTION_BITS + 1;
  // The divider takes one step for the integer bit and one per fraction bit.
  localparam int unsigned STEP_W            = $clog2(FRACTION_BITS + 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_sample;
  } in_beat_t;

  typedef struct packed {
    logic [SCALED_BITS-1:0]        scaled;
    logic signed [SAMPLE_BITS-1:0] set_minimum;
    logic signed [SAMPLE_BITS-1:0] set_maximum;
    logic                          final_result;
    logic                          degenerate;
    logic                          overflowed;
  } out_beat_t;

  typedef struct packed {
    logic load;   // store an accepted input beat
    logic rd;     // read the stored sample at the emit index
    logic init;   // start a division on the read sample
    logic step;   // one restoring division step
    logic first;  // the step that forms the integer bit
    logic push;   // move the quotient into the output register
  } cmd_t;

  typedef struct packed {
    logic last_item;  // the emit index points at the last stored sample
    logic out_free;   // the output register can take a beat this cycle
  } sts_t;

endpackage

// File: hdl/mmfs_dp.sv
// Datapath of the min-max feature scaler: sample store, running extremes,
// serial restoring divider and output register.
// Depends on mmfs_pkg.
module mmfs_dp #(
  parameter int unsigned STORE_DEPTH = mmfs_pkg::STORE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mmfs_pkg::cmd_t      cmd_i,
  output mmfs_pkg::sts_t      sts_o,
  input  mmfs_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mmfs_pkg::out_beat_t out_data_o
);

  localparam int unsigned SB    = mmfs_pkg::SAMPLE_BITS;
  localparam int unsigned FB    = mmfs_pkg::FRACTION_BITS;
  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned RNG_W = SB + 1;
  localparam int unsigned REM_W = SB + 2;

  logic signed [SB-1:0] store_q [STORE_DEPTH];
  logic signed [SB-1:0] rdata_q;
  logic [CNT_W-1:0]     count_q;
  logic [IDX_W-1:0]     k_q;
  logic signed [SB-1:0] min_q;
  logic signed [SB-1:0] max_q;
  logic                 drop_q;
  logic [RNG_W-1:0]     range_q;
  logic [REM_W-1:0]     rem_q;
  logic [FB:0]          quo_q;
  logic                 out_valid_q;
  mmfs_pkg::out_beat_t  out_q;

  logic                 has_room;
  logic                 last_item;
  logic                 out_free;
  logic [RNG_W-1:0]     num;
  logic [RNG_W-1:0]     range_d;
  logic [REM_W-1:0]     rem_sh;
  logic                 ge;
  logic                 degen;

  assign has_room  = count_q < CNT_W'(STORE_DEPTH);
  assign last_item = (CNT_W'(k_q) + CNT_W'(1)) == count_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign sts_o     = '{last_item: last_item, out_free: out_free};

  // Both differences are taken one bit wider so they never wrap.
  assign num     = {rdata_q[SB-1], rdata_q} - {min_q[SB-1], min_q};
  assign range_d = {max_q[SB-1], max_q} - {min_q[SB-1], min_q};
  assign degen   = range_q == '0;

  assign rem_sh = cmd_i.first ? rem_q : {rem_q[REM_W-2:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, range_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && has_room) begin
      store_q[count_q[IDX_W-1:0]] <= in_data_i.sample;
    end
    if (cmd_i.rd) begin
      rdata_q <= store_q[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      k_q     <= '0;
      min_q   <= '0;
      max_q   <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.push && last_item) begin
      count_q <= '0;
      k_q     <= '0;
      min_q   <= '0;
      max_q   <= '0;
      drop_q  <= 1'b0;
    end else if (cmd_i.push) begin
      k_q <= k_q + IDX_W'(1);
    end else if (cmd_i.load) begin
      if (has_room) begin
        count_q <= count_q + CNT_W'(1);
        if (count_q == '0 || in_data_i.sample < min_q) begin
          min_q <= in_data_i.sample;
        end
        if (count_q == '0 || in_data_i.sample > max_q) begin
          max_q <= in_data_i.sample;
        end
      end else begin
        drop_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      range_q <= range_d;
      rem_q   <= REM_W'(num);
      quo_q   <= '0;
    end else if (cmd_i.step) begin
      rem_q <= ge ? rem_sh - REM_W'(range_q) : rem_sh;
      quo_q <= {quo_q[FB-1:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.scaled       <= degen ? '0 : quo_q;
      out_q.set_minimum  <= min_q;
      out_q.set_maximum  <= max_q;
      out_q.final_result <= last_item;
      out_q.degenerate   <= degen;
      out_q.overflowed   <= drop_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> out_free) else $error("push while output register is held");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STORE_DEPTH)) else $error("stored count beyond depth");

  a_extremes_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> min_q <= max_q) else $error("minimum above maximum");

  a_clear_after_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push && last_item |=> count_q == '0 && !drop_q)
    else $error("set not cleared after its last beat");

endmodule

// File: hdl/mmfs_ctrl.sv
// Controller of the min-max feature scaler: sequences loading, the per-sample
// read and divide, and the hand-off to the output register.
// Depends on mmfs_pkg.
module mmfs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_final_i,
  output logic           in_ready_o,
  input  mmfs_pkg::sts_t sts_i,
  output mmfs_pkg::cmd_t cmd_o
);

  localparam int unsigned SW = mmfs_pkg::STEP_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_READ,
    S_INIT,
    S_DIV,
    S_PUSH
  } state_e;

  state_e          state_q;
  logic [SW-1:0]   step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      step_q  <= '0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_valid_i && in_final_i) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_INIT;
        end
        S_INIT: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + SW'(1);
          if (step_q == SW'(mmfs_pkg::FRACTION_BITS)) begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (sts_i.out_free) begin
            state_q <= sts_i.last_item ? S_LOAD : S_READ;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = (state_q == S_LOAD) && in_valid_i;
    cmd_o.rd    = state_q == S_READ;
    cmd_o.init  = state_q == S_INIT;
    cmd_o.step  = state_q == S_DIV;
    cmd_o.first = (state_q == S_DIV) && (step_q == '0);
    cmd_o.push  = (state_q == S_PUSH) && sts_i.out_free;
  end

  assign in_ready_o = state_q == S_LOAD;

  a_no_load_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !cmd_o.push && !cmd_o.step) else $error("load during emission");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> step_q <= SW'(mmfs_pkg::FRACTION_BITS))
    else $error("divider step count overrun");

  a_final_starts_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load && in_final_i |=> state_q == S_READ)
    else $error("final beat did not start emission");

endmodule

// File: hdl/min_max_feature_scaler.sv
// Min-max feature scaler, top level.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one sample per beat.
// Loading accepts one beat per cycle; samples beyond STORE_DEPTH are dropped
// and every result of that set then carries overflowed.
// The beat marked final_sample closes the set. in_ready_o then stays low
// while the stored samples go out, in arrival order, on the output channel
// (out_valid_o / out_ready_i / out_data_o), each scaled to
// (v - min) / (max - min) as an unsigned Q1.16 fraction, truncated.
// Each result goes through a store read, a setup state, 17 steps of the serial
// restoring divider and a transfer into the output register.
// The divider works on the next result while the output register waits; if
// the receiver stalls, the finished quotient holds until the register frees.
// After the beat with final_result is moved, the block takes a new set.
// When maximum equals minimum, scaled is 0 and degenerate is set.
// Reset (rst_ni low) empties the store, clears the extremes and the drop
// flag and drops any pending output beat.
// Depends on mmfs_pkg, mmfs_ctrl and mmfs_dp.
module min_max_feature_scaler #(
  parameter int unsigned STORE_DEPTH = mmfs_pkg::STORE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mmfs_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mmfs_pkg::out_beat_t out_data_o
);

  mmfs_pkg::cmd_t cmd;
  mmfs_pkg::sts_t sts;

  mmfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_final_i (in_data_i.final_sample),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mmfs_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
